### src/dhq_pkg.sv
package dhq_pkg;

	localparam int CHANNELS_DEF  = 10;
	localparam int TIME_BITS_DEF = 32;

	localparam int LEVEL_W   = 10;
	localparam int SCORE_W   = 4;
	localparam int ADDR_W    = 3;
	localparam int CFG_W     = 40;
	localparam int CFG_IDX_W = 3;
	localparam int SETTLE_W  = 8;
	localparam int TICKS_W   = 16;
	localparam int LIMIT_W   = 5;
	localparam int MAP_W     = 40;
	localparam int CNT_W     = 5;

	localparam logic [CNT_W-1:0] CNT_MAX = 5'd31;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STUCK   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STARTUP = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SCORES  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ADDRESS = 3'd7;

	localparam logic [SETTLE_W-1:0] SETTLE_RST  = 8'd1;
	localparam logic [TICKS_W-1:0]  HOLDOFF_RST = 16'd1000;
	localparam logic [TICKS_W-1:0]  STUCK_RST   = 16'd1000;
	localparam logic [TICKS_W-1:0]  WINDOW_RST  = 16'd5000;
	localparam logic [LIMIT_W-1:0]  LIMIT_RST   = 5'd10;
	localparam logic [TICKS_W-1:0]  STARTUP_RST = 16'd2000;

	typedef struct packed {
		logic commit;
		logic rd;
		logic started;
		logic hit_taken;
		logic settle_gt;
		logic hold_gt;
		logic stuck_gt;
		logic win_lt;
	} dhq_ctl_t;

	typedef struct packed {
		logic press;
		logic report;
	} dhq_stat_t;

	typedef struct packed {
		logic gt;
		logic lt;
	} dhq_cmp_t;

endpackage

### src/dhq_in_if.sv
interface dhq_in_if import dhq_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [LEVEL_W-1:0] levels;

	modport source (output valid, output levels, input ready);
	modport sink (input valid, input levels, output ready);
endinterface

### src/dhq_out_if.sv
interface dhq_out_if import dhq_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               hit_valid;
	logic [SCORE_W-1:0] hit_score;
	logic [ADDR_W-1:0]  hit_address;
	logic [LEVEL_W-1:0] enabled_mask;

	modport source (output valid, output hit_valid, output hit_score, output hit_address,
		output enabled_mask, input ready);
	modport sink (input valid, input hit_valid, input hit_score, input hit_address,
		input enabled_mask, output ready);
endinterface

### src/debounce_hit_qualifier_top.sv
// Debounce hit qualifier.
// Input channel "tick": one item per millisecond tick, carrying the ten
// active-low trigger levels. Output channel "result": exactly one item per
// tick with hit_valid, hit_score, hit_address and enabled_mask.
// Configuration: cfg_we / cfg_index / cfg_data, to be written by the user
// only while idle; the block itself does not enforce this. Each tick is
// handled by a sequencer around one shared subtract-and-compare unit:
// first the startup gate, then four compares per channel (settle, hold-off,
// stuck-low, bounce window), channels in index order. tick.ready is low
// from acceptance until the sequencer is back in idle, so no new item is
// accepted before the last one is through.
// The result register parts the two sides: the next tick is accepted while
// a result still waits. If the receiver stalls so long that a second result
// is ready, the block waits in its last step until the register frees.
// Reset clears all channel state, the tick counter and the configuration to
// its defaults; all channels come out of reset enabled.
module debounce_hit_qualifier_top import dhq_pkg::*; #(
	parameter int CHANNELS  = CHANNELS_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	dhq_in_if.sink               tick,
	dhq_out_if.source            result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int EXT_W  = (CHANNELS > LEVEL_W) ? CHANNELS : LEVEL_W;
	localparam int MAPX_W = (SCORE_W * CHANNELS > MAP_W) ? SCORE_W * CHANNELS : MAP_W;
	localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_START = 2'd1;
	localparam logic [1:0] ST_CHAN  = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	localparam logic [1:0] PH_SETTLE = 2'd0;
	localparam logic [1:0] PH_HOLD   = 2'd1;
	localparam logic [1:0] PH_STUCK  = 2'd2;
	localparam logic [1:0] PH_WINDOW = 2'd3;

	logic [SETTLE_W-1:0]  settle_q;
	logic [TICKS_W-1:0]   holdoff_q, stuck_q, window_q, startup_q;
	logic [LIMIT_W-1:0]   limit_q;
	logic [MAP_W-1:0]     scores_q;
	logic [ADDR_W-1:0]    address_q;

	logic [1:0]           state_q;
	logic [1:0]           phase_q;
	logic [CH_W-1:0]      ch_q;
	logic [TIME_BITS-1:0] tick_time_q;
	logic [TIME_BITS-1:0] last_press_q;
	logic                 started_q, hit_q;
	logic                 settle_gt_q, hold_gt_q, stuck_gt_q;
	logic [SCORE_W-1:0]   score_q;
	logic [CHANNELS-1:0]  levels_q;
	logic                 out_valid_q;
	logic                 out_hit_q;
	logic [SCORE_W-1:0]   out_score_q;
	logic [ADDR_W-1:0]    out_addr_q;
	logic [LEVEL_W-1:0]   out_mask_q;

	logic [TIME_BITS-1:0] operand;
	logic [TICKS_W-1:0]   thr;
	dhq_cmp_t             cmp;
	dhq_ctl_t             ctl;
	dhq_stat_t            stat;
	logic [TIME_BITS-1:0] ct_rd, ws_rd, pt_rd;
	logic [CHANNELS-1:0]  en_mask;
	logic [EXT_W-1:0]     lv_ext;
	logic [MAPX_W-1:0]    map_ext;
	logic [SCORE_W-1:0]   score_sel;
	logic [EXT_W-1:0]     mask_ext;
	logic                 load_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q  <= SETTLE_RST;
			holdoff_q <= HOLDOFF_RST;
			stuck_q   <= STUCK_RST;
			window_q  <= WINDOW_RST;
			limit_q   <= LIMIT_RST;
			startup_q <= STARTUP_RST;
			scores_q  <= '0;
			address_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SETTLE:  settle_q  <= cfg_data[SETTLE_W-1:0];
				REG_HOLDOFF: holdoff_q <= cfg_data[TICKS_W-1:0];
				REG_STUCK:   stuck_q   <= cfg_data[TICKS_W-1:0];
				REG_WINDOW:  window_q  <= cfg_data[TICKS_W-1:0];
				REG_LIMIT:   limit_q   <= cfg_data[LIMIT_W-1:0];
				REG_STARTUP: startup_q <= cfg_data[TICKS_W-1:0];
				REG_SCORES:  scores_q  <= cfg_data[MAP_W-1:0];
				REG_ADDRESS: address_q <= cfg_data[ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	// operand select for the shared unit
	always_comb begin
		operand = '0;
		thr     = startup_q;
		if (state_q == ST_CHAN) begin
			case (phase_q)
				PH_SETTLE: begin
					operand = ct_rd;
					thr     = TICKS_W'(settle_q);
				end
				PH_HOLD: begin
					operand = last_press_q;
					thr     = holdoff_q;
				end
				PH_STUCK: begin
					operand = pt_rd;
					thr     = stuck_q;
				end
				default: begin
					operand = ws_rd;
					thr     = window_q;
				end
			endcase
		end
	end

	dhq_cmp #(.TIME_BITS(TIME_BITS)) u_cmp (
		.now     (tick_time_q),
		.operand (operand),
		.thr     (thr),
		.res     (cmp)
	);

	assign ctl.commit    = (state_q == ST_CHAN) && (phase_q == PH_WINDOW);
	assign ctl.rd        = levels_q[ch_q];
	assign ctl.started   = started_q;
	assign ctl.hit_taken = hit_q;
	assign ctl.settle_gt = settle_gt_q;
	assign ctl.hold_gt   = hold_gt_q;
	assign ctl.stuck_gt  = stuck_gt_q;
	assign ctl.win_lt    = cmp.lt;

	dhq_chan #(.CHANNELS(CHANNELS), .TIME_BITS(TIME_BITS)) u_chan (
		.clk          (clk),
		.arst_n       (arst_n),
		.ch           (ch_q),
		.now          (tick_time_q),
		.ctl          (ctl),
		.bounce_limit (limit_q),
		.change_time  (ct_rd),
		.window_start (ws_rd),
		.press_time   (pt_rd),
		.stat         (stat),
		.en_mask      (en_mask)
	);

	// channels past the level field read as pressed, past the map score zero
	assign lv_ext    = EXT_W'(tick.levels);
	assign map_ext   = MAPX_W'(scores_q);
	assign score_sel = map_ext[SCORE_W * ch_q +: SCORE_W];
	assign mask_ext  = EXT_W'(en_mask);
	assign load_out  = (state_q == ST_DONE) && (!out_valid_q || result.ready);

	assign tick.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			phase_q      <= PH_SETTLE;
			ch_q         <= '0;
			tick_time_q  <= '0;
			last_press_q <= '0;
			started_q    <= 1'b0;
			hit_q        <= 1'b0;
			settle_gt_q  <= 1'b0;
			hold_gt_q    <= 1'b0;
			stuck_gt_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (result.valid && result.ready && !load_out) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (tick.valid) begin
						state_q <= ST_START;
					end
				end
				ST_START: begin
					started_q <= cmp.gt;
					hit_q     <= 1'b0;
					ch_q      <= '0;
					phase_q   <= PH_SETTLE;
					state_q   <= ST_CHAN;
				end
				ST_CHAN: begin
					phase_q <= phase_q + 2'd1;
					case (phase_q)
						PH_SETTLE: settle_gt_q <= cmp.gt;
						PH_HOLD:   hold_gt_q   <= cmp.gt;
						PH_STUCK:  stuck_gt_q  <= cmp.gt;
						default: begin
							if (stat.report) begin
								hit_q <= 1'b1;
							end
							if (stat.press) begin
								last_press_q <= tick_time_q;
							end
							if (ch_q == LAST_CH) begin
								state_q <= ST_DONE;
							end else begin
								ch_q <= ch_q + 1'b1;
							end
						end
					endcase
				end
				default: begin
					// hold until the result register frees
					if (load_out) begin
						out_valid_q <= 1'b1;
						tick_time_q <= tick_time_q + 1'b1;
						state_q     <= ST_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			levels_q <= lv_ext[CHANNELS-1:0];
		end
		if (stat.report) begin
			score_q <= score_sel;
		end
		if (load_out) begin
			out_hit_q   <= hit_q;
			out_score_q <= hit_q ? score_q : '0;
			out_addr_q  <= hit_q ? address_q : '0;
			out_mask_q  <= mask_ext[LEVEL_W-1:0];
		end
	end

	assign result.valid        = out_valid_q;
	assign result.hit_valid    = out_hit_q;
	assign result.hit_score    = out_score_q;
	assign result.hit_address  = out_addr_q;
	assign result.enabled_mask = out_mask_q;

	a_start_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(tick.valid && tick.ready) |=> (state_q == ST_START))
		else $error("sequencer did not start after an accepted item");

	a_no_reenable: assert property (@(posedge clk) disable iff (!arst_n)
		(en_mask & ~$past(en_mask)) == '0)
		else $error("disabled channel came back");

	a_time_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_time_q != $past(tick_time_q)) |-> ($past(state_q) == ST_DONE))
		else $error("tick time moved outside the final step");

	a_quiet_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.hit_valid) |->
		(result.hit_score == '0 && result.hit_address == '0))
		else $error("score or address set without a hit");

endmodule

### src/dhq_cmp.sv
module dhq_cmp import dhq_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic [TIME_BITS-1:0] now,
	input  logic [TIME_BITS-1:0] operand,
	input  logic [TICKS_W-1:0]   thr,
	output dhq_cmp_t             res
);

	logic [TIME_BITS-1:0] diff;
	logic [TIME_BITS-1:0] thr_ext;

	// elapsed ticks wrap modulo the time width
	assign diff    = now - operand;
	assign thr_ext = TIME_BITS'(thr);
	assign res.gt  = diff > thr_ext;
	assign res.lt  = diff < thr_ext;

endmodule

### src/dhq_chan.sv
module dhq_chan import dhq_pkg::*; #(
	parameter int CHANNELS  = CHANNELS_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF,
	localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [CH_W-1:0]      ch,
	input  logic [TIME_BITS-1:0] now,
	input  dhq_ctl_t             ctl,
	input  logic [LIMIT_W-1:0]   bounce_limit,
	output logic [TIME_BITS-1:0] change_time,
	output logic [TIME_BITS-1:0] window_start,
	output logic [TIME_BITS-1:0] press_time,
	output dhq_stat_t            stat,
	output logic [CHANNELS-1:0]  en_mask
);

	logic [CHANNELS-1:0]  raw_q;
	logic [CHANNELS-1:0]  qual_q;
	logic [CHANNELS-1:0]  rep_q;
	logic [CHANNELS-1:0]  en_q;
	logic [TIME_BITS-1:0] ct_q [CHANNELS];
	logic [TIME_BITS-1:0] ws_q [CHANNELS];
	logic [TIME_BITS-1:0] pt_q [CHANNELS];
	logic [CNT_W-1:0]     cc_q [CHANNELS];

	logic                 raw_r, q_r, rep_r, en_r;
	logic [CNT_W-1:0]     cc_r;
	logic                 changed, press, report;
	logic                 raw_n, q_n, rep_n, en_n;
	logic [TIME_BITS-1:0] ct_n, ws_n, pt_n;
	logic [CNT_W-1:0]     cc_n;

	assign raw_r        = raw_q[ch];
	assign q_r          = qual_q[ch];
	assign rep_r        = rep_q[ch];
	assign en_r         = en_q[ch];
	assign cc_r         = cc_q[ch];
	assign change_time  = ct_q[ch];
	assign window_start = ws_q[ch];
	assign press_time   = pt_q[ch];
	assign en_mask      = en_q;

	always_comb begin
		changed = (ctl.rd != raw_r) && en_r;
		raw_n   = changed ? ctl.rd : raw_r;
		ct_n    = changed ? now : change_time;
		cc_n    = cc_r;
		if (changed && cc_r != CNT_MAX) begin
			cc_n = cc_r + 1'b1;
		end

		// a fresh raw change leaves zero quiet ticks, so it never settles here
		q_n   = q_r;
		pt_n  = press_time;
		press = 1'b0;
		if (!changed && ctl.settle_gt && en_r && ctl.rd != q_r) begin
			if (!ctl.rd) begin
				if (ctl.hold_gt) begin
					q_n   = 1'b0;
					pt_n  = now;
					press = 1'b1;
				end
			end else begin
				q_n = 1'b1;
			end
		end

		// a press taken this tick has zero elapsed time
		en_n = en_r;
		if (!q_n && en_r && ctl.stuck_gt && !press) begin
			en_n = 1'b0;
			q_n  = 1'b1;
		end

		ws_n = window_start;
		if (en_n && ctl.win_lt) begin
			if (cc_n > bounce_limit) begin
				en_n = 1'b0;
				q_n  = 1'b1;
				cc_n = '0;
				ws_n = now;
			end
		end else if (en_n) begin
			cc_n = '0;
			ws_n = now;
		end else begin
			cc_n = '0;
		end

		rep_n  = rep_r;
		report = 1'b0;
		if (ctl.started && en_n) begin
			if (!q_n && rep_r) begin
				if (!ctl.hit_taken) begin
					report = 1'b1;
					rep_n  = 1'b0;
				end
			end else if (q_n && !rep_r) begin
				rep_n = 1'b1;
			end
		end
	end

	assign stat.press  = ctl.commit && press;
	assign stat.report = ctl.commit && report;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q  <= '1;
			qual_q <= '1;
			rep_q  <= '1;
			en_q   <= '1;
			for (int i = 0; i < CHANNELS; i++) begin
				ct_q[i] <= '0;
				ws_q[i] <= '0;
				pt_q[i] <= '0;
				cc_q[i] <= '0;
			end
		end else if (ctl.commit) begin
			raw_q[ch]  <= raw_n;
			qual_q[ch] <= q_n;
			rep_q[ch]  <= rep_n;
			en_q[ch]   <= en_n;
			ct_q[ch]   <= ct_n;
			ws_q[ch]   <= ws_n;
			pt_q[ch]   <= pt_n;
			cc_q[ch]   <= cc_n;
		end
	end

endmodule
